// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file sle_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed one cycle later");

`endif

// ===== design/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted list engine package
// Shared widths, command codes and transaction types.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 5;
  localparam int POS_SPAN     = 2 ** POS_W;
  localparam int CNT_OUT_W    = 6;
  localparam int CAPACITY_DEF = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_OUT_W-1:0]     count;
    logic                     empty_res;
    logic                     full_res;
  } rsp_t;

  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } ctrl_t;

endpackage

// ===== design/sorted_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// Sorted list engine
// Keeps up to CAPACITY signed values in ascending order in a row of cells.
//
// The cmd channel carries one command per transaction: insert, remove, or
// read at a position. The rsp channel returns one result per command with
// the success flag, read data, entry count and empty and full flags.
// Each command is applied to the row of cells in the cycle it is accepted;
// every cell compares its entry with the command value and shifts in one
// step, so the result appears on rsp in the cycle after acceptance and a new
// command can be accepted each cycle, one per cycle while no result stalls.
// The result register holds while the receiver stalls; cmd_stall is raised
// only while a held result is stalled. Reset empties the list and drops any
// pending result; stored entries are left as they are.
// ----------------------------------------------------------------------------
module sorted_list_engine_top #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  sle_pkg::req_t cmd_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sle_pkg::rsp_t rsp_data
);
  import sle_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic                     accept;
  logic                     full;
  logic                     found;
  logic                     read_ok;
  ctrl_t                    ctrl;
  logic [CNT_W-1:0]         cnt;
  logic [CNT_W-1:0]         cnt_next;
  logic [CNT_W+5:0]         cnt_wide;
  logic signed [DATA_W-1:0] rd_or;
  logic                     rsp_valid_next;
  rsp_t                     rsp_data_next;

  logic signed [DATA_W-1:0] ent   [CAPACITY];
  logic signed [DATA_W-1:0] rd_d  [CAPACITY];
  logic [CAPACITY-1:0]      gt_v;
  logic [CAPACITY-1:0]      lt_v;
  logic [CAPACITY-1:0]      eq_v;
  logic [CAPACITY-1:0]      hit_v;

  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign full      = cnt == CNT_W'(CAPACITY);
  assign found     = |eq_v;
  assign read_ok   = |hit_v;

  assign ctrl.ins      = accept && (cmd_data.cmd == CMD_INSERT) && !full;
  assign ctrl.rem      = accept && (cmd_data.cmd == CMD_REMOVE) && found;
  assign ctrl.value    = cmd_data.value;
  assign ctrl.position = cmd_data.position;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] lower_entry;
    logic                     lower_gt;
    logic                     lower_lt;
    logic signed [DATA_W-1:0] upper_entry;

    if (i == 0) begin : g_first
      assign lower_entry = '0;
      assign lower_gt    = 1'b0;
      assign lower_lt    = 1'b1;
    end else begin : g_mid
      assign lower_entry = ent[i-1];
      assign lower_gt    = gt_v[i-1];
      assign lower_lt    = lt_v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper_entry = ent[i];
    end else begin : g_up
      assign upper_entry = ent[i+1];
    end

    sle_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .count       (cnt),
      .lower_entry (lower_entry),
      .lower_gt    (lower_gt),
      .lower_lt    (lower_lt),
      .upper_entry (upper_entry),
      .entry       (ent[i]),
      .gt          (gt_v[i]),
      .lt          (lt_v[i]),
      .first_eq    (eq_v[i]),
      .rd_hit      (hit_v[i]),
      .rd_data     (rd_d[i])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | rd_d[i];
    end
  end

  always_comb begin
    cnt_next = cnt;
    if (ctrl.ins) begin
      cnt_next = cnt + CNT_W'(1);
    end else if (ctrl.rem) begin
      cnt_next = cnt - CNT_W'(1);
    end
  end

  assign cnt_wide = (CNT_W + 6)'(cnt_next);

  always_comb begin
    rsp_data_next            = '0;
    rsp_data_next.count      = cnt_wide[CNT_OUT_W-1:0];
    rsp_data_next.empty_res  = cnt_next == '0;
    rsp_data_next.full_res   = cnt_next == CNT_W'(CAPACITY);
    case (cmd_data.cmd)
      CMD_INSERT: begin
        rsp_data_next.ok = !full;
      end
      CMD_REMOVE: begin
        rsp_data_next.ok = found;
      end
      CMD_READ: begin
        rsp_data_next.ok         = read_ok;
        rsp_data_next.read_value = rd_or;
      end
      default: begin
        rsp_data_next.ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid && rsp_stall;
    if (accept) begin
      rsp_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      cnt       <= cnt_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data <= rsp_data_next;
    end
  end

endmodule

// ===== design/sle_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted list cell
// One slot of the list: compares its entry with the command value and
// takes its own, a neighbor's or the new value on insert and remove.
// ----------------------------------------------------------------------------
module sle_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  logic                              clk,
  input  sle_pkg::ctrl_t                    ctrl,
  input  logic [CNT_W-1:0]                  count,
  input  logic signed [sle_pkg::DATA_W-1:0] lower_entry,
  input  logic                              lower_gt,
  input  logic                              lower_lt,
  input  logic signed [sle_pkg::DATA_W-1:0] upper_entry,
  output logic signed [sle_pkg::DATA_W-1:0] entry,
  output logic                              gt,
  output logic                              lt,
  output logic                              first_eq,
  output logic                              rd_hit,
  output logic signed [sle_pkg::DATA_W-1:0] rd_data
);
  import sle_pkg::*;

  localparam logic [CNT_W-1:0] SLOT = CNT_W'(IDX);

  logic                     occ;
  logic                     at_tail;
  logic                     pos_hit;
  logic signed [DATA_W-1:0] entry_next;

  assign occ      = SLOT < count;
  assign at_tail  = SLOT == count;
  assign gt       = occ && (entry > ctrl.value);
  assign lt       = occ && (entry < ctrl.value);
  assign first_eq = occ && (entry == ctrl.value) && lower_lt;
  assign pos_hit  = (IDX < POS_SPAN) && (32'(ctrl.position) == 32'(IDX));
  assign rd_hit   = occ && pos_hit;
  assign rd_data  = rd_hit ? entry : '0;

  always_comb begin
    entry_next = entry;
    if (ctrl.ins) begin
      if (lower_gt) begin
        entry_next = lower_entry;
      end else if (gt || at_tail) begin
        entry_next = ctrl.value;
      end
    end else if (ctrl.rem) begin
      if (occ && !lt) begin
        entry_next = upper_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== design/sle_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted list engine checker
// Port-level checks on the command and response channels, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sle_checker (
  input logic          clk,
  input logic          rst,
  input logic          cmd_valid,
  input logic          cmd_stall,
  input sle_pkg::req_t cmd_data,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input sle_pkg::rsp_t rsp_data
);
  import sle_pkg::*;

  logic cmd_taken;

  assign cmd_taken = cmd_valid && !cmd_stall && (cmd_data.cmd == cmd_data.cmd);

  `ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
  `ASSERT_NEXT(a_rsp_follows, cmd_taken, rsp_valid)
  `ASSERT_SAME(a_stall_cause, cmd_stall, rsp_valid && rsp_stall)
  `ASSERT_SAME(a_fail_zero, rsp_valid && !rsp_data.ok, rsp_data.read_value == '0)

endmodule

bind sorted_list_engine_top sle_checker u_sle_checker (.*);
